### rtl/bb3_pkg.sv
// bb3_pkg: shared types, constants and the reciprocal table of the 3x3 box blur
// used by bb3_front, bb3_queue, bb3_back and box_blur_3x3_edge_clipped_core
// no dependencies
package bb3_pkg;

    localparam int COL_W       = 11;
    localparam int ROW_W       = 14;
    localparam int HGT_W       = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int SUM_W       = 12;
    localparam int NUM_W       = 13;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [COL_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             last;
        logic [8:0]       mask;
        logic [CNT_W-1:0] count;
    } blur_item_t;

    // ceil(2^19 / count): exact rounded quotient of (2*sum + count) / (2*count)
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        begin
            case (count)
                4'd1:    r = 20'd524288;
                4'd2:    r = 20'd262144;
                4'd3:    r = 20'd174763;
                4'd4:    r = 20'd131072;
                4'd5:    r = 20'd104858;
                4'd6:    r = 20'd87382;
                4'd7:    r = 20'd74899;
                4'd8:    r = 20'd65536;
                4'd9:    r = 20'd58255;
                default: r = 20'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/bb3_front.sv
// bb3_front: config registers, input position counters and item classification
// computes the neighbour mask, count and last flag for each item
// depends on bb3_pkg
module bb3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            flush,
    input  logic [7:0]                      red_in,
    input  logic [7:0]                      green_in,
    input  logic [7:0]                      blue_in,
    input  logic                            q_full,
    output logic                            push,
    output bb3_pkg::blur_item_t             push_item
);
    import bb3_pkg::*;

    localparam logic [13:0] MAX_W14 = 14'(MAX_WIDTH);

    logic [COL_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;

    logic [COL_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [ROW_W-1:0] h_ext;
    logic [COL_W:0]   w_ext;
    logic [COL_W:0]   in_col_inc;
    logic [COL_W:0]   out_col_inc;
    logic [ROW_W:0]   out_row_inc;
    logic             accept;
    logic             in_frame;
    logic             edge_col;
    logic             started;
    logic             last;
    logic             out_col_end;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [8:0]       mask;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = 11'd1;
        else if ({3'b0, width_reg} > MAX_W14)
            w_eff = MAX_W14[COL_W-1:0];
        else
            w_eff = width_reg;
        h_eff = (height_reg == '0) ? 13'd1 : height_reg;
    end

    assign h_ext       = {1'b0, h_eff};
    assign w_ext       = {1'b0, w_eff};
    assign in_col_inc  = {1'b0, in_col_reg} + 1'b1;
    assign out_col_inc = {1'b0, out_col_reg} + 1'b1;
    assign out_row_inc = {1'b0, out_row_reg} + 1'b1;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign in_frame = in_row_reg < h_ext;
    assign push     = accept && !(in_frame && flush);

    assign edge_col = (in_col_reg == '0);
    assign started  = (in_row_reg >= 14'd2) || ((in_row_reg == 14'd1) && !edge_col);

    assign out_col_end = out_col_inc >= w_ext;
    assign last = started && (out_row_inc >= {1'b0, h_ext}) && out_col_end;

    // mask in the coordinates of the window after the shift
    assign row_ok[0] = (out_row_reg != '0);
    assign row_ok[1] = (out_row_reg < h_ext);
    assign row_ok[2] = (out_row_inc < {1'b0, h_ext});
    assign col_ok[0] = (out_col_reg != '0);
    assign col_ok[1] = ({1'b0, out_col_reg} < w_ext);
    assign col_ok[2] = !edge_col && (out_col_inc < w_ext);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mask[r*3+c] = row_ok[r] && col_ok[c];
            end
        end
    end

    always_comb
    begin
        push_item.red   = in_frame ? red_in : 8'd0;
        push_item.green = in_frame ? green_in : 8'd0;
        push_item.blue  = in_frame ? blue_in : 8'd0;
        push_item.col   = in_col_reg;
        push_item.emit  = started;
        push_item.last  = last;
        push_item.mask  = mask;
        push_item.count = CNT_W'($countones(mask));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[COL_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[HGT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (push)
        begin
            if (last)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                if (in_col_inc >= w_ext)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_inc[COL_W-1:0];
                end
                if (started)
                begin
                    if (out_col_end)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_inc[COL_W-1:0];
                    end
                end
            end
        end
    end

endmodule

### rtl/bb3_queue.sv
// bb3_queue: short item queue between the front and back parts
// depends on bb3_pkg
module bb3_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bb3_pkg::blur_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output bb3_pkg::blur_item_t q_item
);
    import bb3_pkg::*;

    blur_item_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/bb3_back.sv
// bb3_back: line stores, 3x3 window, masked sums and rounded division
// three stages: line store read, window and sums, divide into the output register
// depends on bb3_pkg
module bb3_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  bb3_pkg::blur_item_t q_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          red_out,
    output logic [7:0]          green_out,
    output logic [7:0]          blue_out,
    output logic                last_of_frame
);
    import bb3_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [23:0] line_prev_mem [MAX_WIDTH];
    logic [23:0] line_old_mem  [MAX_WIDTH];

    logic             advance;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [23:0]      s1_pix;
    logic [23:0]      s1_prev;
    logic [23:0]      s1_old;

    // stage 1: item with line store data
    logic             s1_valid_reg;
    blur_item_t       s1_item_reg;
    logic [23:0]      rd_prev_reg;
    logic [23:0]      rd_old_reg;
    logic             fwd_reg;
    logic [23:0]      fwd_prev_reg;
    logic [23:0]      fwd_old_reg;

    logic [23:0]      win_reg  [9];
    logic [23:0]      win_next [9];
    logic [SUM_W-1:0] sum_next [3];

    // stage 2: sums
    logic             s2_valid_reg;
    logic             s2_last_reg;
    logic [CNT_W-1:0] s2_count_reg;
    logic [SUM_W-1:0] s2_sum_reg [3];

    // stage 3: output
    logic             out_valid_reg;
    logic             out_last_reg;
    logic [7:0]       out_pix_reg [3];

    logic [RECIP_W-1:0]         recip_val;
    logic [NUM_W-1:0]           num [3];
    logic [NUM_W+RECIP_W-1:0]   prod [3];

    assign advance = !(out_valid_reg && out_stall);
    assign pop     = advance && q_valid;
    assign rd_addr = AW'(q_item.col);
    assign wr_addr = AW'(s1_item_reg.col);
    assign s1_pix  = {s1_item_reg.red, s1_item_reg.green, s1_item_reg.blue};
    assign s1_prev = fwd_reg ? fwd_prev_reg : rd_prev_reg;
    assign s1_old  = fwd_reg ? fwd_old_reg : rd_old_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s1_valid_reg)
            begin
                line_prev_mem[wr_addr] <= s1_pix;
                line_old_mem[wr_addr]  <= s1_prev;
            end
            rd_prev_reg <= line_prev_mem[rd_addr];
            rd_old_reg  <= line_old_mem[rd_addr];
        end
    end

    // same column written in the cycle of the read
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg  <= q_item;
            fwd_reg      <= s1_valid_reg && (wr_addr == rd_addr);
            fwd_prev_reg <= s1_pix;
            fwd_old_reg  <= s1_prev;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3+0] = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = s1_old;
        win_next[5] = s1_prev;
        win_next[8] = s1_pix;
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_next[ch] = '0;
            for (int i = 0; i < 9; i++)
            begin
                if (s1_item_reg.mask[i])
                    sum_next[ch] = sum_next[ch] + SUM_W'(win_next[i][(2-ch)*8 +: 8]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_last_reg  <= s1_item_reg.last;
            s2_count_reg <= s1_item_reg.count;
            for (int ch = 0; ch < 3; ch++)
            begin
                s2_sum_reg[ch] <= sum_next[ch];
            end
        end
    end

    assign recip_val = recip(s2_count_reg);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            num[ch]  = {s2_sum_reg[ch], 1'b0} + NUM_W'(s2_count_reg);
            prod[ch] = (NUM_W+RECIP_W)'(num[ch]) * (NUM_W+RECIP_W)'(recip_val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_last_reg <= s2_last_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                out_pix_reg[ch] <= prod[ch][RECIP_SHIFT +: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg && s1_item_reg.emit;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_out       = out_pix_reg[0];
    assign green_out     = out_pix_reg[1];
    assign blue_out      = out_pix_reg[2];
    assign last_of_frame = out_last_reg;

endmodule

### rtl/box_blur_3x3_edge_clipped_core.sv
// box_blur_3x3_edge_clipped_core: top level of the streaming 3x3 box blur
// instantiates bb3_front, bb3_queue and bb3_back; depends on bb3_pkg
//
// Streams RGB pixels of a frame in raster order and returns the 3x3 box-blurred
// frame in the same order, each channel averaged over the neighbours inside the
// frame and rounded half up. One item is taken per clock cycle unless in_stall is
// high; the blurred pixel for a position leaves frame_width+1 items after its
// input; after a frame's last pixel frame_width+1 flush items drain the rest.
// A flush item inside the frame is dropped without effect. The final result
// carries last_of_frame, after which a new frame starts. An accepted item passes
// through the queue slot, the line store read, the window sum and the rounded
// division into the output register. Two line stores of MAX_WIDTH entries each
// are simple dual-port memories, read at one column and written at another once
// per item; they need no clearing after reset. Configuration writes take effect
// at once and should be made between frames.
module box_blur_3x3_edge_clipped_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            flush,
    input  logic [7:0]                      red_in,
    input  logic [7:0]                      green_in,
    input  logic [7:0]                      blue_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      red_out,
    output logic [7:0]                      green_out,
    output logic [7:0]                      blue_out,
    output logic                            last_of_frame
);
    import bb3_pkg::*;

    logic       push;
    blur_item_t push_item;
    logic       q_full;
    logic       q_valid;
    blur_item_t q_item;
    logic       pop;

    bb3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .flush     (flush),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    bb3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    bb3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .last_of_frame (last_of_frame)
    );

endmodule

### tb/tb_box_blur_3x3_edge_clipped_core.sv
`timescale 1ns / 100ps
// tb_box_blur_3x3_edge_clipped_core: self-checking testbench of the streaming 3x3 box blur
// drives frames of edge-case and random sizes, predicts every blurred pixel in a scoreboard
// depends on bb3_pkg and box_blur_3x3_edge_clipped_core
module tb_box_blur_3x3_edge_clipped_core;
    import bb3_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int CLK_HALF      = 10;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } blur_pixel_t;

    typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_FULL, PIX_ZERO} pixel_kind_t;

    class blur_scoreboard;
        bit [23:0]       line_prev [LINE_DEPTH];
        bit [23:0]       line_older [LINE_DEPTH];
        bit [23:0]       window [9];
        int unsigned     in_col, in_row, out_col, out_row;
        bit [COL_W-1:0]  width_reg = WIDTH_RESET;
        bit [HGT_W-1:0]  height_reg = HEIGHT_RESET;
        blur_pixel_t     blurred_due [$];
        bit              frame_done;
        int unsigned     effective_items, frames, checked, errors;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_FRAME_WIDTH)
                width_reg = value[COL_W-1:0];
            else
                height_reg = value[HGT_W-1:0];
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > LINE_DEPTH)
                return LINE_DEPTH;
            return int'(width_reg);
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        // average of the in-frame neighbours around the output position, then advance it
        function blur_pixel_t blur_window(int ccol, int unsigned w, int unsigned h);
            int unsigned sum_r, sum_g, sum_b, count, q;
            int          c;
            blur_pixel_t res;
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            count = 0;
            for (int dr = -1; dr <= 1; dr++)
            begin
                if (dr < 0 && out_row < 1) continue;
                if (dr == 0 && out_row >= h) continue;
                if (dr > 0 && out_row + 1 >= h) continue;
                for (int dc = -1; dc <= 1; dc++)
                begin
                    c = ccol + dc;
                    if (c < 0 || c > 2) continue;
                    if (dc < 0 && out_col < 1) continue;
                    if (dc == 0 && out_col >= w) continue;
                    if (dc > 0 && out_col + 1 >= w) continue;
                    sum_r += 32'(window[(dr + 1) * 3 + c][23:16]);
                    sum_g += 32'(window[(dr + 1) * 3 + c][15:8]);
                    sum_b += 32'(window[(dr + 1) * 3 + c][7:0]);
                    count++;
                end
            end
            if (count == 0)
            begin
                res.red   = 8'h00;
                res.green = 8'h00;
                res.blue  = 8'h00;
            end
            else
            begin
                q = (2 * sum_r + count) / (2 * count);
                res.red = q[7:0];
                q = (2 * sum_g + count) / (2 * count);
                res.green = q[7:0];
                q = (2 * sum_b + count) / (2 * count);
                res.blue = q[7:0];
            end
            res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
            if (out_col + 1 >= w)
            begin
                out_col = 0;
                out_row++;
            end
            else
                out_col++;
            return res;
        endfunction

        // note an accepted item; returns 0 when the block ignores it
        function bit take_pixel(logic fl, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned w, h, col;
            bit [23:0]   px;
            bit          at_left, started, ends_frame;
            blur_pixel_t res;
            w = eff_width();
            h = eff_height();
            px = {r, g, b};
            col = in_col % LINE_DEPTH;
            at_left = (col == 0);
            started = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            ends_frame = 1'b0;
            frame_done = 1'b0;
            if (in_row < h)
            begin
                if (fl)
                    return 1'b0;
            end
            else
                px = '0;
            // right-edge output still sees its columns before the shift
            if (started && at_left)
            begin
                res = blur_window(2, w, h);
                blurred_due.push_back(res);
                ends_frame = res.last;
            end
            for (int k = 0; k < 9; k += 3)
            begin
                window[k]     = window[k + 1];
                window[k + 1] = window[k + 2];
            end
            window[2] = line_older[col];
            window[5] = line_prev[col];
            window[8] = px;
            line_older[col] = line_prev[col];
            line_prev[col] = px;
            if (started && !at_left)
            begin
                res = blur_window(1, w, h);
                blurred_due.push_back(res);
                ends_frame = res.last;
            end
            if (ends_frame)
            begin
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
                frame_done = 1'b1;
                frames++;
            end
            else if (in_col + 1 >= w)
            begin
                in_col = 0;
                in_row++;
            end
            else
                in_col++;
            effective_items++;
            return 1'b1;
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
            blur_pixel_t want;
            checked++;
            if (blurred_due.size() == 0)
            begin
                $error("blurred pixel with none due: red %0d green %0d blue %0d last %0b",
                       r, g, b, last);
                errors++;
                return;
            end
            want = blurred_due.pop_front();
            if (r !== want.red)
            begin
                $error("red_out: expected %0d, got %0d", want.red, r);
                errors++;
            end
            if (g !== want.green)
            begin
                $error("green_out: expected %0d, got %0d", want.green, g);
                errors++;
            end
            if (b !== want.blue)
            begin
                $error("blue_out: expected %0d, got %0d", want.blue, b);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_of_frame: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  flush;
    logic [7:0]            red_in;
    logic [7:0]            green_in;
    logic [7:0]            blue_in;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            red_out;
    logic [7:0]            green_out;
    logic [7:0]            blue_out;
    logic                  last_of_frame;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    blur_scoreboard sb = new();

    box_blur_3x3_edge_clipped_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .flush         (flush),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .last_of_frame (last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid === 1'b1 && !out_stall)
            sb.check_pixel(red_out, green_out, blue_out, last_of_frame);

    function automatic logic [7:0] pick_chan(pixel_kind_t kind);
        case (kind)
            PIX_EXTREME: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            PIX_FULL:    return 8'hFF;
            PIX_ZERO:    return 8'h00;
            default:     return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input logic fl, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        flush    <= fl;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        void'(sb.take_pixel(fl, r, g, b));
    endtask

    task automatic send_pixels(input int n);
        repeat (n)
            send_item(1'b0, pick_chan(PIX_RANDOM), pick_chan(PIX_RANDOM), pick_chan(PIX_RANDOM));
    endtask

    // rest of the frame, then drain items until the last blurred pixel is due
    task automatic finish_frame(input pixel_kind_t kind, input int noise_pct,
                                input int drain_data_pct);
        int guard;
        guard = 0;
        do
        begin
            if (sb.in_row < sb.eff_height())
            begin
                if ($urandom_range(99) < noise_pct)
                    send_item(1'b1, pick_chan(PIX_RANDOM), pick_chan(PIX_RANDOM),
                              pick_chan(PIX_RANDOM));
                else
                    send_item(1'b0, pick_chan(kind), pick_chan(kind), pick_chan(kind));
            end
            else
                send_item($urandom_range(99) >= drain_data_pct, pick_chan(PIX_RANDOM),
                          pick_chan(PIX_RANDOM), pick_chan(PIX_RANDOM));
            guard++;
        end
        while (!sb.frame_done && guard < 20000);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.blurred_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        sb.write_reg(CFG_FRAME_WIDTH, w);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        sb.write_reg(CFG_FRAME_HEIGHT, h);
        cfg_write <= 1'b0;
    endtask

    task automatic random_frame();
        int                    pick;
        logic [CFG_DATA_W-1:0] w, h;
        if ($urandom_range(3) != 0)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                w = '0;
            else if (pick < 75)
                w = CFG_DATA_W'($urandom_range(10, 1));
            else
                w = CFG_DATA_W'($urandom_range(40, 11));
            h = ($urandom_range(99) < 4) ? '0 : CFG_DATA_W'($urandom_range(6, 1));
            wait_idle();
            set_frame(w, h);
        end
        finish_frame(PIX_RANDOM, 8, 20);
    endtask

    task automatic random_phase(input int unsigned target);
        int unsigned start;
        start = sb.effective_items;
        while (sb.effective_items - start < target)
            random_frame();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        flush     <= 1'b0;
        red_in    <= 8'h00;
        green_in  <= 8'h00;
        blue_in   <= 8'h00;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 59;
        // zero sizes, flush inside the frame, extreme pixels, pixel data during the drain
        set_frame(0, 0);
        send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
        finish_frame(PIX_FULL, 0, 0);
        wait_idle();
        set_frame(3, 1);
        finish_frame(PIX_EXTREME, 0, 0);
        wait_idle();
        set_frame(1, 3);
        finish_frame(PIX_EXTREME, 0, 0);
        wait_idle();
        set_frame(2, 2);
        finish_frame(PIX_EXTREME, 0, 100);
        random_phase(360);

        send_idle_pct = 59;
        recv_idle_pct = 35;
        // sizes changed mid-frame with the pipeline empty
        wait_idle();
        set_frame(5, 4096);
        send_pixels(15);
        wait_idle();
        set_frame(5, 1);
        finish_frame(PIX_RANDOM, 0, 0);
        wait_idle();
        set_frame(12, 8191);
        send_pixels(33);
        wait_idle();
        set_frame(4, 5);
        finish_frame(PIX_RANDOM, 8, 20);
        random_phase(360);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // width above the line store depth, then narrowed mid-frame
        wait_idle();
        set_frame(2047, 8191);
        send_pixels(20);
        wait_idle();
        set_frame(6, 2);
        finish_frame(PIX_RANDOM, 2, 10);
        random_phase(360);

        wait_idle();
        $display("run covered %0d items, %0d blurred pixels checked over %0d frames",
                 sb.effective_items, sb.checked, sb.frames);
        $display("widths 0 to 2047, heights 0 to 8191, mid-frame resizes, three stall mixes");
        if (sb.errors == 0)
            $display("** box_blur_3x3_edge_clipped_core: PASSED **");
        else
            $display("** box_blur_3x3_edge_clipped_core: FAILED **");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("** box_blur_3x3_edge_clipped_core: FAILED **");
        $finish;
    end

endmodule

### files.f
rtl/bb3_pkg.sv
rtl/bb3_front.sv
rtl/bb3_queue.sv
rtl/bb3_back.sv
rtl/box_blur_3x3_edge_clipped_core.sv
tb/tb_box_blur_3x3_edge_clipped_core.sv
